// File: rtl/srsd_pkg.sv
// Shared types and constants for the stable record depth sorter.
package srsd_pkg;

  localparam int unsigned CapacityDefault = 32;

  typedef struct packed {
    logic signed [15:0] key;
    logic signed [15:0] row;
    logic [6:0]         shade;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } slot_t;

  typedef struct packed {
    logic ins;
    logic drain;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

// File: rtl/srsd_cell.sv
// One cell of the insertion chain: holds one record, shifts right on insert, left on drain.
module srsd_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  srsd_pkg::cell_ctl_t ctl,
  input  srsd_pkg::rec_t    new_rec,
  input  srsd_pkg::slot_t   left_slot,
  input  logic              left_shift,
  input  srsd_pkg::slot_t   right_slot,
  output srsd_pkg::slot_t   slot,
  output logic              shift
);
  import srsd_pkg::*;

  logic valid_r, valid_nxt;
  rec_t rec_r, rec_nxt;

  assign shift = !valid_r || (rec_r.key > new_rec.key);

  always_comb begin
    valid_nxt = valid_r;
    rec_nxt   = rec_r;
    if (ctl.drain) begin
      valid_nxt = right_slot.valid;
      rec_nxt   = right_slot.rec;
    end else if (ctl.ins && shift) begin
      if (left_shift) begin
        valid_nxt = left_slot.valid;
        rec_nxt   = left_slot.rec;
      end else begin
        valid_nxt = 1'b1;
        rec_nxt   = new_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    rec_r <= rec_nxt;
  end

  assign slot.valid = valid_r;
  assign slot.rec   = rec_r;

endmodule

// File: rtl/stable_record_sort_by_depth.sv
// Top level of the stable record depth sorter: cell chain, load/drain control, result register.
//
// Records enter one per cycle while busy is low; each one is placed into a chain of CAPACITY
// cells in the cycle it is accepted, every cell comparing its key with the new one and handing
// its record to its right neighbor when displaced, so equal keys keep arrival order. The
// transaction flagged final starts the drain: busy rises and the chain shifts toward cell 0
// one record per cycle, with each result on the out_ ports for one cycle under out_valid,
// registered in the cycle after it reaches cell 0. The receiver cannot stall, so results
// must be taken as they come. Records that arrive with all cells full are dropped, and
// every result of that run carries out_dropped.
module stable_record_sort_by_depth #(
  parameter int unsigned CAPACITY = srsd_pkg::CapacityDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_depth_key,
  input  logic signed [15:0] in_row_pos,
  input  logic [6:0]         in_shade_base,
  input  logic               in_is_final,
  output logic               out_valid,
  output logic signed [15:0] out_key,
  output logic signed [15:0] out_row,
  output logic [6:0]         out_shade,
  output logic               out_end_of_run,
  output logic               out_dropped
);
  import srsd_pkg::*;

  state_t    state_r, state_nxt;
  logic      overflow_r, overflow_nxt;
  logic      out_valid_r;
  rec_t      out_rec_r;
  logic      out_end_r;
  logic      out_drop_r;
  rec_t      new_rec;
  cell_ctl_t ctl;
  logic      accept;
  logic      full;
  slot_t     slots [CAPACITY];
  logic      shifts [CAPACITY];

  assign new_rec.key   = in_depth_key;
  assign new_rec.row   = in_row_pos;
  assign new_rec.shade = in_shade_base;

  assign busy   = (state_r == ST_DRAIN);
  assign accept = start && !busy;
  assign full   = slots[CAPACITY-1].valid;

  assign ctl.ins   = accept && !full;
  assign ctl.drain = busy;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t left_s;
    slot_t right_s;
    logic  left_sh;
    if (i == 0) begin : g_first
      assign left_s  = '0;
      assign left_sh = 1'b0;
    end else begin : g_mid
      assign left_s  = slots[i-1];
      assign left_sh = shifts[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_s = '0;
    end else begin : g_inner
      assign right_s = slots[i+1];
    end
    srsd_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_rec    (new_rec),
      .left_slot  (left_s),
      .left_shift (left_sh),
      .right_slot (right_s),
      .slot       (slots[i]),
      .shift      (shifts[i])
    );
  end

  always_comb begin
    state_nxt    = state_r;
    overflow_nxt = overflow_r;
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (full) begin
            overflow_nxt = 1'b1;
          end
          if (in_is_final) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!slots[1].valid) begin
          state_nxt    = ST_LOAD;
          overflow_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= busy;
    end
    out_rec_r  <= slots[0].rec;
    out_end_r  <= !slots[1].valid;
    out_drop_r <= overflow_r;
  end

  assign out_valid      = out_valid_r;
  assign out_key        = out_rec_r.key;
  assign out_row        = out_rec_r.row;
  assign out_shade      = out_rec_r.shade;
  assign out_end_of_run = out_end_r;
  assign out_dropped    = out_drop_r;

endmodule
